FILE: rtl/sirt_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer to radix text: shared package
// Widths, character codes, the configuration and job types, and the
// reciprocal table used by the digit divider.
// ----------------------------------------------------------------------------
package sirt_pkg;

	localparam int NUMBER_WIDTH = 32;
	localparam int MAX_RADIX    = 16;
	localparam int RADIX_W      = 5;
	localparam int CHAR_W       = 8;
	localparam int DIGIT_W      = 4;
	localparam int TABLE_W      = MAX_RADIX * CHAR_W;
	localparam int CNT_W        = $clog2(NUMBER_WIDTH + 1);
	localparam int SP_W         = $clog2(NUMBER_WIDTH);
	localparam int REM_W        = $clog2(2 * MAX_RADIX);
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

	typedef struct packed {
		logic [RADIX_W-1:0] radix_length;
		logic [TABLE_W-1:0] digit_chars;
	} cfg_t;

	typedef struct packed {
		logic                    neg;
		logic [NUMBER_WIDTH-1:0] mag;
	} job_t;

	// Floor of 2^32 divided by the radix.
	function automatic logic [NUMBER_WIDTH-1:0] recip(input logic [RADIX_W-1:0] d);
		logic [NUMBER_WIDTH-1:0] r;
		case (d)
			5'd2:    r = 32'h8000_0000;
			5'd3:    r = 32'h5555_5555;
			5'd4:    r = 32'h4000_0000;
			5'd5:    r = 32'h3333_3333;
			5'd6:    r = 32'h2AAA_AAAA;
			5'd7:    r = 32'h2492_4924;
			5'd8:    r = 32'h2000_0000;
			5'd9:    r = 32'h1C71_C71C;
			5'd10:   r = 32'h1999_9999;
			5'd11:   r = 32'h1745_D174;
			5'd12:   r = 32'h1555_5555;
			5'd13:   r = 32'h13B1_3B13;
			5'd14:   r = 32'h1249_2492;
			5'd15:   r = 32'h1111_1111;
			5'd16:   r = 32'h1000_0000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/sirt_front.sv
// ----------------------------------------------------------------------------
// Signed integer to radix text: front end
// Registers an incoming number, checks the radix and digit alphabet, forms the sign and
// magnitude, and hands good jobs to the queue. Jobs with a bad alphabet or radix drop.
// ----------------------------------------------------------------------------
module sirt_front
	import sirt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    number_valid,
	output logic                    number_ready,
	input  logic [NUMBER_WIDTH-1:0] number,
	output logic                    job_valid,
	input  logic                    job_ready,
	output job_t                    job
);

	logic                    valid_s1;
	logic [NUMBER_WIDTH-1:0] number_s1;
	logic                    alpha_ok;
	logic                    bad;
	logic                    consume;
	logic [CHAR_W-1:0]       bi;

	always_comb begin
		bad = (cfg.radix_length < RADIX_W'(2)) || (cfg.radix_length > RADIX_W'(MAX_RADIX));
		bi = '0;
		for (int i = 0; i < MAX_RADIX; i++) begin
			bi = cfg.digit_chars[i*CHAR_W +: CHAR_W];
			if ((RADIX_W'(i) < cfg.radix_length) && ((bi == CH_PLUS) || (bi == CH_MINUS))) begin
				bad = 1'b1;
			end
			for (int j = i + 1; j < MAX_RADIX; j++) begin
				if ((RADIX_W'(j) < cfg.radix_length) &&
				    (bi == cfg.digit_chars[j*CHAR_W +: CHAR_W])) begin
					bad = 1'b1;
				end
			end
		end
		alpha_ok = !bad;
	end

	assign job.neg      = number_s1[NUMBER_WIDTH-1];
	assign job.mag      = number_s1[NUMBER_WIDTH-1] ? (~number_s1 + NUMBER_WIDTH'(1)) : number_s1;
	assign job_valid    = valid_s1 && alpha_ok;
	assign consume      = valid_s1 && (!alpha_ok || job_ready);
	assign number_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			number_s1 <= '0;
		end else begin
			if (number_ready) begin
				valid_s1 <= number_valid;
				if (number_valid) begin
					number_s1 <= number;
				end
			end
		end
	end

endmodule

FILE: rtl/sirt_queue.sv
// ----------------------------------------------------------------------------
// Signed integer to radix text: job queue
// A short first-in first-out queue between the front end and the converter.
// ----------------------------------------------------------------------------
module sirt_queue
	import sirt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QC_W-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != QC_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QC_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QC_W'(1);
			end
		end
	end

endmodule

FILE: rtl/sirt_back.sv
// ----------------------------------------------------------------------------
// Signed integer to radix text: converter
// Divides the magnitude by the radix, one digit at a time, through a reciprocal
// multiply and a correction step, pushes the digits on a stack, then pops them
// out as characters behind an output register, led by a minus sign if negative.
// ----------------------------------------------------------------------------
module sirt_back
	import sirt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              job_valid,
	output logic              job_ready,
	input  job_t              job,
	output logic              char_valid,
	input  logic              char_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CORR,
		ST_POP,
		ST_SIGN,
		ST_SHOW
	} state_t;

	state_t                    st_q;
	logic [NUMBER_WIDTH-1:0]   m_q;
	logic [NUMBER_WIDTH-1:0]   qest_s1;
	logic                      neg_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      char_valid_q;
	logic [CHAR_W-1:0]         char_q;
	logic                      last_q;

	logic [DIGIT_W-1:0]        stack [NUMBER_WIDTH];
	logic [DIGIT_W-1:0]        rd_q;
	logic                      rd_en;
	logic [SP_W-1:0]           rd_addr;
	logic                      wr_en;

	logic [2*NUMBER_WIDTH-1:0] prod;
	logic [NUMBER_WIDTH-1:0]   qd;
	logic [NUMBER_WIDTH-1:0]   rem_full;
	logic [REM_W-1:0]          rem;
	logic                      fix;
	logic [DIGIT_W-1:0]        digit;
	logic [NUMBER_WIDTH-1:0]   q_next;
	logic [CNT_W-1:0]          cnt_m1;
	logic [CNT_W-1:0]          cnt_m2;
	logic                      out_free;
	logic                      emit_word;

	assign prod     = (2*NUMBER_WIDTH)'(m_q) * (2*NUMBER_WIDTH)'(recip(cfg.radix_length));
	assign qd       = qest_s1 * NUMBER_WIDTH'(cfg.radix_length);
	assign rem_full = m_q - qd;
	assign rem      = rem_full[REM_W-1:0];
	assign fix      = (rem >= REM_W'(cfg.radix_length));
	assign digit    = fix ? DIGIT_W'(rem - REM_W'(cfg.radix_length)) : DIGIT_W'(rem);
	assign q_next   = qest_s1 + NUMBER_WIDTH'(fix);
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign cnt_m2   = cnt_q - CNT_W'(2);
	assign out_free = !char_valid_q || char_ready;
	assign emit_word = ((st_q == ST_SIGN) || (st_q == ST_SHOW)) && out_free;

	assign job_ready  = (st_q == ST_IDLE);
	assign char_valid = char_valid_q;
	assign character  = char_q;
	assign last       = last_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		case (st_q)
			ST_CORR: begin
				wr_en = (cnt_q < CNT_W'(NUMBER_WIDTH));
			end
			ST_POP: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m1[SP_W-1:0];
			end
			ST_SHOW: begin
				rd_en   = out_free && (cnt_q != CNT_W'(1));
				rd_addr = cnt_m2[SP_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack[cnt_q[SP_W-1:0]] <= digit;
		end
		if (rd_en) begin
			rd_q <= stack[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			m_q          <= '0;
			qest_s1      <= '0;
			neg_q        <= 1'b0;
			cnt_q        <= '0;
			char_valid_q <= 1'b0;
			char_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			if (emit_word) begin
				char_valid_q <= 1'b1;
			end else if (char_ready) begin
				char_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						m_q   <= job.mag;
						neg_q <= job.neg;
						cnt_q <= '0;
						st_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					qest_s1 <= prod[2*NUMBER_WIDTH-1:NUMBER_WIDTH];
					st_q    <= ST_CORR;
				end
				ST_CORR: begin
					m_q <= q_next;
					if (cnt_q < CNT_W'(NUMBER_WIDTH)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					st_q <= (q_next == '0) ? ST_POP : ST_MUL;
				end
				ST_POP: begin
					st_q <= neg_q ? ST_SIGN : ST_SHOW;
				end
				ST_SIGN: begin
					if (out_free) begin
						char_q <= CH_MINUS;
						last_q <= 1'b0;
						st_q   <= ST_SHOW;
					end
				end
				ST_SHOW: begin
					if (out_free) begin
						char_q <= cfg.digit_chars[int'(rd_q)*CHAR_W +: CHAR_W];
						last_q <= (cnt_q == CNT_W'(1));
						cnt_q  <= cnt_m1;
						if (cnt_q == CNT_W'(1)) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// Division only runs with a radix that passed the alphabet check.
	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CORR) |-> ((cfg.radix_length >= RADIX_W'(2)) &&
		                       (cfg.radix_length <= RADIX_W'(MAX_RADIX))))
		else $error("division with an invalid radix");

	// The digit stack never overflows.
	a_stack_room: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CORR) |-> (cnt_q < CNT_W'(NUMBER_WIDTH)))
		else $error("digit stack overflow");

	// Every popped digit was pushed first.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_POP) || (st_q == ST_SIGN) || (st_q == ST_SHOW)) |-> (cnt_q != '0))
		else $error("pop from an empty digit stack");

	// The final digit goes out flagged as last; only then does the converter return to idle for the next job.
	a_last_before_next: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_SHOW) && out_free && (cnt_q == CNT_W'(1))) |=> (char_valid_q && last_q))
		else $error("final digit not flagged as last");
`endif

endmodule

FILE: rtl/signed_integer_to_radix_text.sv
// Flow: the converter takes a job, divides out each digit in its reciprocal divider,
// reads the stack, then emits each character; it takes no new job until the last one is in its output register.
// Reset: arst_n clears the registers, queue and converter; the digit stack needs no clearing.
// ----------------------------------------------------------------------------
// Signed integer to radix text: top level
// Holds the configuration registers and connects the front end, the job
// queue and the converter.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text
	import sirt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [63:0]             pwdata,
	output logic [63:0]             prdata,
	output logic                    pready,
	input  logic                    number_valid,
	output logic                    number_ready,
	input  logic [NUMBER_WIDTH-1:0] number,
	output logic                    char_valid,
	input  logic                    char_ready,
	output logic [CHAR_W-1:0]       character,
	output logic                    last
);

	localparam logic [1:0] REG_RADIX_LENGTH = 2'd0;
	localparam logic [1:0] REG_CHARS_LOW    = 2'd1;
	localparam logic [1:0] REG_CHARS_HIGH   = 2'd2;

	logic [RADIX_W-1:0] radix_q;
	logic [63:0]        chars_low_q;
	logic [63:0]        chars_high_q;
	logic               cfg_wr;
	cfg_t               cfg;
	logic               q_push_valid;
	logic               q_push_ready;
	job_t               q_push_job;
	logic               q_pop_valid;
	logic               q_pop_ready;
	job_t               q_pop_job;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= '0;
			chars_low_q  <= '0;
			chars_high_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				REG_RADIX_LENGTH: radix_q      <= pwdata[RADIX_W-1:0];
				REG_CHARS_LOW:    chars_low_q  <= pwdata;
				REG_CHARS_HIGH:   chars_high_q <= pwdata;
				default: begin
					radix_q <= radix_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_RADIX_LENGTH: prdata = 64'(radix_q);
			REG_CHARS_LOW:    prdata = chars_low_q;
			REG_CHARS_HIGH:   prdata = chars_high_q;
			default:          prdata = '0;
		endcase
	end

	assign cfg.radix_length = radix_q;
	assign cfg.digit_chars  = {chars_high_q, chars_low_q};

	sirt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.number_valid (number_valid),
		.number_ready (number_ready),
		.number       (number),
		.job_valid    (q_push_valid),
		.job_ready    (q_push_ready),
		.job          (q_push_job)
	);

	sirt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_job   (q_push_job),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_job    (q_pop_job)
	);

	sirt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.job_valid  (q_pop_valid),
		.job_ready  (q_pop_ready),
		.job        (q_pop_job),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.character  (character),
		.last       (last)
	);

endmodule

FILE: tb/sv/tb_signed_integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to radix text: testbench
// Sets the digit alphabet and radix over the register port, feeds signed
// numbers, and checks every character word and its last flag against a
// predictor kept in step with the register writes. Good and bad alphabets
// are both exercised, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_radix_text;
	import sirt_pkg::*;

	localparam int REG_RADIX_LENGTH     = 0;
	localparam int REG_DIGIT_CHARS_LOW  = 1;
	localparam int REG_DIGIT_CHARS_HIGH = 2;
	localparam int REG_UNUSED           = 3;
	localparam int SETTLE_CYCLES        = 400;
	localparam int RANDOM_NUMBERS       = 400;

	typedef struct {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [4:0]              paddr = '0;
	logic [63:0]             pwdata = '0;
	logic [63:0]             prdata;
	logic                    pready;
	logic                    number_valid = 1'b0;
	logic                    number_ready;
	logic [NUMBER_WIDTH-1:0] number = '0;
	logic                    char_valid;
	logic                    char_ready = 1'b0;
	logic [CHAR_W-1:0]       character;
	logic                    last;

	logic [RADIX_W-1:0]      radix_shadow = '0;
	logic [TABLE_W-1:0]      alphabet_shadow = '0;
	logic [NUMBER_WIDTH-1:0] number_backlog[$];
	text_word_t              expected_text[$];
	bit                      quiet_in = 1'b0;
	bit                      quiet_out = 1'b0;
	int                      send_gap = 0;
	int                      stall_left = 0;
	int                      mismatches = 0;
	int                      numbers_converted = 0;
	int                      numbers_dropped = 0;
	int                      words_checked = 0;
	int                      settings_used = 0;

	signed_integer_to_radix_text u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.number_valid (number_valid),
		.number_ready (number_ready),
		.number       (number),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.character    (character),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("signed_integer_to_radix_text: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 30) begin
			$display("ERROR at %0t ns: %s", $realtime, what);
		end
		mismatches++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Works out the text of one number under the current radix and alphabet.
	function automatic void predict_text(input logic [NUMBER_WIDTH-1:0] value);
		int                      len;
		logic [CHAR_W-1:0]       a;
		logic [NUMBER_WIDTH-1:0] mag;
		logic [NUMBER_WIDTH-1:0] base;
		logic [DIGIT_W-1:0]      digits[NUMBER_WIDTH];
		int                      count;
		text_word_t              w;
		len = radix_shadow;
		if (len < 2 || len > MAX_RADIX) begin
			numbers_dropped++;
			return;
		end
		for (int i = 0; i < len; i++) begin
			a = alphabet_shadow[i*CHAR_W +: CHAR_W];
			if (a == CH_PLUS || a == CH_MINUS) begin
				numbers_dropped++;
				return;
			end
			for (int j = i + 1; j < len; j++) begin
				if (a == alphabet_shadow[j*CHAR_W +: CHAR_W]) begin
					numbers_dropped++;
					return;
				end
			end
		end
		numbers_converted++;
		mag = value[NUMBER_WIDTH-1] ? ~value + 1'b1 : value;
		base = NUMBER_WIDTH'(len);
		count = 0;
		do begin
			digits[count] = DIGIT_W'(mag % base);
			count++;
			mag = mag / base;
		end while (mag != 0);
		if (value[NUMBER_WIDTH-1]) begin
			w.character = CH_MINUS;
			w.last = 1'b0;
			expected_text.push_back(w);
		end
		for (int k = count - 1; k >= 0; k--) begin
			w.character = alphabet_shadow[digits[k]*CHAR_W +: CHAR_W];
			w.last = (k == 0);
			expected_text.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (number_valid && number_ready) begin
				predict_text(number);
			end
			if (number_valid && !number_ready) begin
				number_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				number_valid <= 1'b0;
			end else if (number_backlog.size() > 0) begin
				number <= number_backlog.pop_front();
				number_valid <= 1'b1;
				send_gap = quiet_in ? 0 : gap_len();
			end else begin
				number_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		text_word_t w;
		if (!arst_n) begin
			char_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (char_valid && char_ready) begin
				words_checked++;
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("word 0x%02h with nothing expected", character));
				end else begin
					w = expected_text.pop_front();
					if (character !== w.character) begin
						report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
							character, w.character));
					end
					if (last !== w.last) begin
						report_mismatch($sformatf("last %b, expected %b on character 0x%02h",
							last, w.last, w.character));
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				char_ready <= 1'b0;
			end else begin
				char_ready <= 1'b1;
				if (!quiet_out && $urandom_range(0, 3) == 0) begin
					stall_left = gap_len();
				end
			end
		end
	end

	task automatic write_reg(input int index, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(index * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_RADIX_LENGTH:     radix_shadow = value[RADIX_W-1:0];
			REG_DIGIT_CHARS_LOW:  alphabet_shadow[63:0] = value;
			REG_DIGIT_CHARS_HIGH: alphabet_shadow[127:64] = value;
			default: ;
		endcase
	endtask

	task automatic set_alphabet(input logic [RADIX_W-1:0] len, input logic [TABLE_W-1:0] tbl);
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		w[RADIX_W-1:0] = len;
		write_reg(REG_RADIX_LENGTH, w);
		write_reg(REG_DIGIT_CHARS_LOW, tbl[63:0]);
		write_reg(REG_DIGIT_CHARS_HIGH, tbl[127:64]);
		settings_used++;
	endtask

	task automatic drain_block();
		@(negedge clk);
		while (number_backlog.size() != 0 || number_valid || expected_text.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [TABLE_W-1:0] pack_alphabet(input string s);
		logic [TABLE_W-1:0] t;
		t = '0;
		for (int i = 0; i < s.len() && i < MAX_RADIX; i++) t[i*CHAR_W +: CHAR_W] = s[i];
		return t;
	endfunction

	// Distinct, sign-free bytes below len; anything above it.
	function automatic logic [TABLE_W-1:0] random_alphabet(input int len);
		logic [TABLE_W-1:0] t;
		logic [CHAR_W-1:0]  b;
		bit                 clash;
		t = '0;
		for (int i = 0; i < MAX_RADIX; i++) begin
			do begin
				b = $urandom_range(0, 255);
				if ($urandom_range(0, 15) == 0) b = 8'h00;
				clash = 1'b0;
				if (i < len) begin
					if (b == CH_PLUS || b == CH_MINUS) clash = 1'b1;
					for (int j = 0; j < i; j++)
						if (t[j*CHAR_W +: CHAR_W] == b) clash = 1'b1;
				end
			end while (clash);
			t[i*CHAR_W +: CHAR_W] = b;
		end
		return t;
	endfunction

	function automatic logic [NUMBER_WIDTH-1:0] random_number();
		int                      r;
		longint                  p;
		longint                  base;
		logic [NUMBER_WIDTH-1:0] v;
		r = $urandom_range(0, 9);
		base = (radix_shadow >= 2 && radix_shadow <= MAX_RADIX) ? radix_shadow : 10;
		case (r)
			0, 1, 2, 3: v = $urandom();
			4, 5: v = $urandom_range(0, 40);
			6: begin
				case ($urandom_range(0, 4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h0;
					default: v = 32'h1;
				endcase
				return v;
			end
			7: begin
				p = 1;
				repeat ($urandom_range(1, 31)) if (p * base <= 64'h8000_0000) p = p * base;
				v = NUMBER_WIDTH'(p + $urandom_range(0, 2) - 1);
			end
			default: v = $urandom() >> $urandom_range(0, 31);
		endcase
		if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
		return v;
	endfunction

	initial begin
		logic [TABLE_W-1:0] tbl;
		int                 len;
		int                 n;
		int                 i;
		int                 j;
		int                 random_left;
		random_left = RANDOM_NUMBERS;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Registers still at reset: radix zero, so nothing comes out.
		number_backlog.push_back(32'd0);
		number_backlog.push_back(32'd5);
		drain_block();

		set_alphabet(5'd10, pack_alphabet("0123456789ABCDEF"));
		number_backlog.push_back(32'd0);
		number_backlog.push_back(32'd1);
		number_backlog.push_back(32'hFFFF_FFFF);
		number_backlog.push_back(32'h7FFF_FFFF);
		number_backlog.push_back(32'h8000_0000);
		number_backlog.push_back(-32'sd10);
		number_backlog.push_back(32'd1_000_000_000);
		drain_block();

		set_alphabet(5'd2, pack_alphabet("01"));
		// A write to the unused address must leave the alphabet alone.
		write_reg(REG_UNUSED, 64'h2D2D_2D2D_2D2D_2D2D);
		number_backlog.push_back(32'h7FFF_FFFF);
		number_backlog.push_back(32'h8000_0000);
		number_backlog.push_back(32'd0);
		number_backlog.push_back(32'hFFFF_FFFF);
		drain_block();

		tbl = pack_alphabet("x123456789abcdef");
		tbl[7:0] = 8'h00;
		set_alphabet(5'd16, tbl);
		number_backlog.push_back(32'h8000_0000);
		number_backlog.push_back(32'hFFFF_FFFF);
		number_backlog.push_back(32'h7FFF_FFFF);
		number_backlog.push_back(32'h1234_5678);
		drain_block();

		// Repeated byte just past the used length is harmless.
		set_alphabet(5'd3, pack_alphabet("abca-+"));
		number_backlog.push_back(32'd5);
		number_backlog.push_back(-32'sd7);
		drain_block();

		set_alphabet(5'd1, pack_alphabet("0123456789"));
		number_backlog.push_back(32'd3);
		drain_block();
		set_alphabet(5'd17, pack_alphabet("0123456789ABCDEF"));
		number_backlog.push_back(32'd3);
		drain_block();
		set_alphabet(5'd31, pack_alphabet("0123456789ABCDEF"));
		number_backlog.push_back(32'd3);
		drain_block();
		set_alphabet(5'd10, pack_alphabet("0123456709"));
		number_backlog.push_back(32'd3);
		drain_block();
		set_alphabet(5'd10, pack_alphabet("01234+6789"));
		number_backlog.push_back(32'd3);
		drain_block();
		set_alphabet(5'd16, pack_alphabet("0123456789ABCDE-"));
		number_backlog.push_back(32'd3);
		drain_block();

		while (random_left > 0) begin
			quiet_in = ($urandom_range(0, 3) == 0);
			quiet_out = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0) begin
				len = $urandom_range(2, MAX_RADIX);
				tbl = random_alphabet(len);
				i = $urandom_range(0, len - 2);
				j = $urandom_range(i + 1, len - 1);
				case ($urandom_range(0, 3))
					0: begin
						len = $urandom_range(0, 1);
						if ($urandom_range(0, 1) == 1) len = $urandom_range(MAX_RADIX + 1, 31);
					end
					1: tbl[i*CHAR_W +: CHAR_W] = tbl[j*CHAR_W +: CHAR_W];
					2: tbl[j*CHAR_W +: CHAR_W] = CH_PLUS;
					default: tbl[i*CHAR_W +: CHAR_W] = CH_MINUS;
				endcase
				set_alphabet(RADIX_W'(len), tbl);
				repeat (5) number_backlog.push_back(random_number());
			end else begin
				case ($urandom_range(0, 3))
					0: len = 2;
					1: len = MAX_RADIX;
					default: len = $urandom_range(2, MAX_RADIX);
				endcase
				set_alphabet(RADIX_W'(len), random_alphabet(len));
				n = $urandom_range(10, 40);
				if (n > random_left) n = random_left;
				repeat (n) number_backlog.push_back(random_number());
				random_left -= n;
			end
			drain_block();
		end

		$display("Converted %0d numbers under %0d register settings, %0d character words checked.",
			numbers_converted, settings_used, words_checked);
		$display("%0d numbers were refused for a bad alphabet or radix.", numbers_dropped);
		if (mismatches == 0) begin
			$display("signed_integer_to_radix_text: match");
		end else begin
			$display("signed_integer_to_radix_text: mismatch");
		end
		$finish;
	end

endmodule
